// File: rtl/pnu_pkg.sv
package pnu_pkg;

   localparam int FUNC_W     = 2;
   localparam int ADDR_W     = 12;
   localparam int COLOR_W    = 16;
   localparam int PIXEL_W    = 8;
   localparam int COORD_W    = 10;
   localparam int STEP_W     = 17;
   localparam int DIM_W      = 11;
   localparam int STRIDE_W   = 12;
   localparam int FRAC_W     = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;
   localparam int PAL_DEPTH  = 256;
   localparam int PAL_AW     = 8;

   localparam logic [STEP_W-1:0]   STEP_RESET   = 17'h10000;
   localparam logic [DIM_W-1:0]    DIM_RESET    = 11'd1;
   localparam logic [STRIDE_W-1:0] STRIDE_RESET = 12'd64;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_LOAD_PAL = 2'd0,
      FUNC_LOAD_SRC = 2'd1,
      FUNC_PRODUCE  = 2'd2
   } func_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STEP_X     = 3'd0,
      CSR_STEP_Y     = 3'd1,
      CSR_DST_WIDTH  = 3'd2,
      CSR_DST_HEIGHT = 3'd3,
      CSR_SRC_STRIDE = 3'd4
   } csr_idx_type;

endpackage

// File: rtl/pnu_ifs.sv
interface pnu_req_if import pnu_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [FUNC_W-1:0]  func;
   logic [ADDR_W-1:0]  addr;
   logic [COLOR_W-1:0] color;
   logic [PIXEL_W-1:0] pixel;

   modport source (output valid, func, addr, color, pixel, input ready);
   modport sink   (input valid, func, addr, color, pixel, output ready);
endinterface

interface pnu_rsp_if import pnu_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COLOR_W-1:0] out_color;
   logic               write_enable;
   logic [COORD_W-1:0] out_x;
   logic [COORD_W-1:0] out_y;
   logic               frame_last;

   modport source (output valid, out_color, write_enable, out_x, out_y, frame_last,
                   input ready);
   modport sink   (input valid, out_color, write_enable, out_x, out_y, frame_last,
                   output ready);
endinterface

interface pnu_csr_if import pnu_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/palette_nearest_upscaler.sv
// Nearest-neighbor upscaler for 8-bit indexed images with a 16-bit palette.
// req_ch carries one transaction per item: func selects a palette load
// (addr, color), a source pixel load (addr, pixel) or the production of the
// next output pixel in raster order. Only produce transactions give a
// transaction on rsp_ch: palette color, write enable (low for index zero,
// color then reads zero), output column and row, and a last-of-frame flag.
// csr_ch writes step_x, step_y, dst_width, dst_height and src_stride; it is
// always ready. The user must write it only while no produce transaction is
// in flight; the block itself does not enforce this. A produce transaction
// is registered through the source memory read and then the palette read
// before it shows on rsp_ch.
// Throughput: one transaction per cycle while rsp_ch does not stall, set by
// the update of the column and row accumulators and the one read port of
// each memory. A stalled rsp_ch holds its transaction; one more produce
// transaction is taken into the source-read stage, then req_ch ready drops
// until the receiver takes the output. Loads are taken under the same ready.
// Reset clears the accumulators, counters and pipeline valid flags and
// resets the configuration; both memories hold nothing defined until written.
module palette_nearest_upscaler import pnu_pkg::*; #(
   parameter int SRC_DEPTH   = 4096,
   parameter int MAX_DST_DIM = 1024
) (
   input logic        clock,
   input logic        reset,
   pnu_req_if.sink    req_ch,
   pnu_rsp_if.source  rsp_ch,
   pnu_csr_if.sink    csr_ch
);

   localparam int SRC_AW = $clog2(SRC_DEPTH);
   localparam int CNT_W  = $clog2(MAX_DST_DIM);
   localparam int DW     = ((DIM_W > CNT_W + 1) ? DIM_W : CNT_W + 1) + 1;
   localparam logic [DW-1:0] MAX_DIM_C = DW'(MAX_DST_DIM);
   localparam logic [DW-1:0] ONE_C     = DW'(1);

   // configuration
   logic [STEP_W-1:0]   step_x_ff, step_y_ff;
   logic [DIM_W-1:0]    dst_width_ff, dst_height_ff;
   logic [STRIDE_W-1:0] src_stride_ff;

   // walk state
   logic [FRAC_W-1:0] frac_x_ff, frac_x_in, frac_y_ff, frac_y_in;
   logic [SRC_AW-1:0] src_col_ff, src_col_in, row_base_ff, row_base_in;
   logic [CNT_W-1:0]  col_cnt_ff, col_cnt_in, row_cnt_ff, row_cnt_in;

   // pipeline
   logic               b_valid_ff, c_valid_ff;
   logic [COORD_W-1:0] b_x_ff, b_y_ff, c_x_ff, c_y_ff;
   logic               b_last_ff, c_last_ff, c_we_ff;

   logic [PIXEL_W-1:0] src_mem [SRC_DEPTH];
   logic [COLOR_W-1:0] pal_mem [PAL_DEPTH];
   logic [PIXEL_W-1:0] src_q;
   logic [COLOR_W-1:0] pal_q;

   logic              req_acc, is_prod, is_ld_pal, is_ld_src;
   logic              c_adv, b_adv;
   logic [SRC_AW-1:0] src_rd_addr, ld_addr, stride_a;
   logic [FRAC_W+1:0] sum_x, sum_y;
   logic              adv_x, adv_y;
   logic [DW-1:0]     wid_ext, hgt_ext, wid_c, hgt_c, col_next, row_next;
   logic              row_end, frame_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_x_ff     <= STEP_RESET;
         step_y_ff     <= STEP_RESET;
         dst_width_ff  <= DIM_RESET;
         dst_height_ff <= DIM_RESET;
         src_stride_ff <= STRIDE_RESET;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_STEP_X:     step_x_ff     <= csr_ch.data;
            CSR_STEP_Y:     step_y_ff     <= csr_ch.data;
            CSR_DST_WIDTH:  dst_width_ff  <= csr_ch.data[DIM_W-1:0];
            CSR_DST_HEIGHT: dst_height_ff <= csr_ch.data[DIM_W-1:0];
            CSR_SRC_STRIDE: src_stride_ff <= csr_ch.data[STRIDE_W-1:0];
            default: ;
         endcase
      end
   end

   assign csr_ch.ready = 1'b1;

   // handshake
   assign c_adv        = !c_valid_ff || rsp_ch.ready;
   assign b_adv        = b_valid_ff && c_adv;
   assign req_ch.ready = !b_valid_ff || c_adv;
   assign req_acc      = req_ch.valid && req_ch.ready;
   assign is_prod      = req_acc && (req_ch.func == FUNC_PRODUCE);
   assign is_ld_pal    = req_acc && (req_ch.func == FUNC_LOAD_PAL);
   assign is_ld_src    = req_acc && (req_ch.func == FUNC_LOAD_SRC);

   assign src_rd_addr = row_base_ff + src_col_ff;
   assign ld_addr     = SRC_AW'(32'(req_ch.addr));
   assign stride_a    = SRC_AW'(32'(src_stride_ff));

   // clamp the sizes to 1..MAX_DST_DIM
   assign wid_ext = DW'(dst_width_ff);
   assign hgt_ext = DW'(dst_height_ff);
   assign wid_c   = (wid_ext == '0) ? ONE_C : ((wid_ext > MAX_DIM_C) ? MAX_DIM_C : wid_ext);
   assign hgt_c   = (hgt_ext == '0) ? ONE_C : ((hgt_ext > MAX_DIM_C) ? MAX_DIM_C : hgt_ext);

   assign col_next  = DW'(col_cnt_ff) + ONE_C;
   assign row_next  = DW'(row_cnt_ff) + ONE_C;
   assign row_end   = col_next >= wid_c;
   assign frame_end = row_end && (row_next >= hgt_c);

   // the integer part moves on by one when the sum leaves 16 bits
   assign sum_x = (FRAC_W+2)'(frac_x_ff) + (FRAC_W+2)'(step_x_ff);
   assign sum_y = (FRAC_W+2)'(frac_y_ff) + (FRAC_W+2)'(step_y_ff);
   assign adv_x = |sum_x[FRAC_W+1:FRAC_W];
   assign adv_y = |sum_y[FRAC_W+1:FRAC_W];

   always_comb begin
      frac_x_in   = frac_x_ff;
      frac_y_in   = frac_y_ff;
      src_col_in  = src_col_ff;
      row_base_in = row_base_ff;
      col_cnt_in  = col_cnt_ff;
      row_cnt_in  = row_cnt_ff;
      if (is_prod) begin
         if (!row_end) begin
            col_cnt_in = col_cnt_ff + CNT_W'(1);
            frac_x_in  = sum_x[FRAC_W-1:0];
            src_col_in = src_col_ff + SRC_AW'(adv_x);
         end else begin
            col_cnt_in = '0;
            frac_x_in  = '0;
            src_col_in = '0;
            if (frame_end) begin
               row_cnt_in  = '0;
               frac_y_in   = '0;
               row_base_in = '0;
            end else begin
               row_cnt_in  = row_cnt_ff + CNT_W'(1);
               frac_y_in   = sum_y[FRAC_W-1:0];
               row_base_in = adv_y ? (row_base_ff + stride_a) : row_base_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frac_x_ff   <= '0;
         frac_y_ff   <= '0;
         src_col_ff  <= '0;
         row_base_ff <= '0;
         col_cnt_ff  <= '0;
         row_cnt_ff  <= '0;
      end else begin
         frac_x_ff   <= frac_x_in;
         frac_y_ff   <= frac_y_in;
         src_col_ff  <= src_col_in;
         row_base_ff <= row_base_in;
         col_cnt_ff  <= col_cnt_in;
         row_cnt_ff  <= row_cnt_in;
      end
   end

   // source memory: read on produce, hold the data while the stage waits
   always_ff @(posedge clock) begin
      if (is_ld_src) begin
         src_mem[ld_addr] <= req_ch.pixel;
      end
      if (is_prod) begin
         src_q <= src_mem[src_rd_addr];
      end
   end

   // palette memory: a load in the same cycle as the read lands after it
   always_ff @(posedge clock) begin
      if (is_ld_pal) begin
         pal_mem[req_ch.addr[PAL_AW-1:0]] <= req_ch.color;
      end
      if (b_adv) begin
         pal_q <= pal_mem[src_q];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         if (req_ch.ready) begin
            b_valid_ff <= is_prod;
         end
         if (c_adv) begin
            c_valid_ff <= b_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (is_prod) begin
         b_x_ff    <= COORD_W'(32'(col_cnt_ff));
         b_y_ff    <= COORD_W'(32'(row_cnt_ff));
         b_last_ff <= frame_end;
      end
      if (b_adv) begin
         c_x_ff    <= b_x_ff;
         c_y_ff    <= b_y_ff;
         c_last_ff <= b_last_ff;
         c_we_ff   <= |src_q;
      end
   end

   assign rsp_ch.valid        = c_valid_ff;
   assign rsp_ch.out_color    = c_we_ff ? pal_q : '0;
   assign rsp_ch.write_enable = c_we_ff;
   assign rsp_ch.out_x        = c_x_ff;
   assign rsp_ch.out_y        = c_y_ff;
   assign rsp_ch.frame_last   = c_last_ff;

endmodule

// File: rtl/pnu_checker.sv
module pnu_checker import pnu_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic [FUNC_W-1:0]  req_func,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [COLOR_W-1:0] rsp_color,
   input logic [COORD_W-1:0] rsp_x,
   input logic [COORD_W-1:0] rsp_y
);

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result present after reset");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_func == FUNC_PRODUCE, 2))
      else $error("result without a produce transaction two cycles before");

   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled while output is free");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_color) && $stable(rsp_x)
         && $stable(rsp_y))
      else $error("stalled result changed");

endmodule

bind palette_nearest_upscaler pnu_checker u_pnu_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .req_func  (req_ch.func),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_color (rsp_ch.out_color),
   .rsp_x     (rsp_ch.out_x),
   .rsp_y     (rsp_ch.out_y)
);

// File: sim/testbench.sv
module testbench;
   import pnu_pkg::*;

   localparam int SRC_SIZE     = 4096;
   localparam int SRC_FILL     = 64;
   localparam int DIM_MAX      = 1024;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_CYCLES = 6;
   localparam int HOLD_CYCLES  = 300;

   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   typedef struct {
      logic [COLOR_W-1:0] color;
      logic               wr_en;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic               last;
   } out_pixel_type;

   logic clock;
   logic reset;

   pnu_req_if req_ch();
   pnu_rsp_if rsp_ch();
   pnu_csr_if csr_ch();

   palette_nearest_upscaler DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // scaler state as the block should hold it
   logic [COLOR_W-1:0]  pal_copy [PAL_DEPTH];
   logic [PIXEL_W-1:0]  src_copy [SRC_SIZE];
   logic [FRAC_W-1:0]   acc_x;
   logic [FRAC_W-1:0]   acc_y;
   logic [ADDR_W-1:0]   column;
   logic [ADDR_W-1:0]   line_base;
   logic [COORD_W-1:0]  col_pos;
   logic [COORD_W-1:0]  row_pos;
   logic [STEP_W-1:0]   cfg_step_x;
   logic [STEP_W-1:0]   cfg_step_y;
   logic [DIM_W-1:0]    cfg_width;
   logic [DIM_W-1:0]    cfg_height;
   logic [STRIDE_W-1:0] cfg_stride;

   out_pixel_type pending_pixels [$];

   bit sender_idles = 1'b1;
   bit sink_idles   = 1'b1;
   int hold_off       = 0;
   int items_sent     = 0;
   int pixels_checked = 0;
   int settings_used  = 0;
   int mismatches     = 0;
   int cycle_count    = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("testbench: FAIL");
      $finish;
   end

   function automatic logic [DIM_W-1:0] clamped(logic [DIM_W-1:0] v);
      if (v == '0) return DIM_W'(1);
      if (v > DIM_MAX) return DIM_W'(DIM_MAX);
      return v;
   endfunction

   function automatic void apply_item(logic [FUNC_W-1:0] f, logic [ADDR_W-1:0] a,
                                      logic [COLOR_W-1:0] c, logic [PIXEL_W-1:0] p);
      out_pixel_type       px;
      logic [PIXEL_W-1:0]  idx;
      logic [ADDR_W-1:0]   rd_addr;
      logic [FRAC_W+1:0]   sum;
      case (f)
         FUNC_LOAD_PAL: pal_copy[a[PAL_AW-1:0]] = c;
         FUNC_LOAD_SRC: src_copy[a] = p;
         FUNC_PRODUCE: begin
            rd_addr  = line_base + column;
            idx      = src_copy[rd_addr];
            px.wr_en = (idx != '0);
            px.color = px.wr_en ? pal_copy[idx] : '0;
            px.x     = col_pos;
            px.y     = row_pos;
            px.last  = 1'b0;
            sum   = acc_x + cfg_step_x;
            acc_x = sum[FRAC_W-1:0];
            if (|sum[FRAC_W+1:FRAC_W]) column = column + 1'b1;
            if ({1'b0, col_pos} + 1 >= clamped(cfg_width)) begin
               col_pos = '0;
               acc_x   = '0;
               column  = '0;
               sum   = acc_y + cfg_step_y;
               acc_y = sum[FRAC_W-1:0];
               if (|sum[FRAC_W+1:FRAC_W]) line_base = line_base + cfg_stride;
               if ({1'b0, row_pos} + 1 >= clamped(cfg_height)) begin
                  px.last   = 1'b1;
                  row_pos   = '0;
                  acc_y     = '0;
                  line_base = '0;
               end else begin
                  row_pos = row_pos + 1'b1;
               end
            end else begin
               col_pos = col_pos + 1'b1;
            end
            pending_pixels.push_back(px);
         end
         default: ;
      endcase
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endfunction

   initial begin : pixel_sink
      int            stall;
      out_pixel_type want;
      stall = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready) begin
            if (pending_pixels.size() == 0) begin
               $error("pixel transaction with no pixel expected");
               mismatches++;
            end else begin
               want = pending_pixels.pop_front();
               check_field("out_color", 32'(want.color), 32'(rsp_ch.out_color));
               check_field("write_enable", 32'(want.wr_en), 32'(rsp_ch.write_enable));
               check_field("out_x", 32'(want.x), 32'(rsp_ch.out_x));
               check_field("out_y", 32'(want.y), 32'(rsp_ch.out_y));
               check_field("frame_last", 32'(want.last), 32'(rsp_ch.frame_last));
               pixels_checked++;
            end
            stall = sink_idles ? $urandom_range(0, 14) : 0;
         end
         @(negedge clock);
         if (hold_off > 0) begin
            hold_off--;
            rsp_ch.ready = 1'b0;
         end else if (stall > 0) begin
            stall--;
            rsp_ch.ready = 1'b0;
         end else begin
            rsp_ch.ready = 1'b1;
         end
      end
   end

   task automatic send_item(logic [FUNC_W-1:0] f, logic [ADDR_W-1:0] a,
                            logic [COLOR_W-1:0] c, logic [PIXEL_W-1:0] p);
      int gap;
      gap = sender_idles ? $urandom_range(0, 14) : 0;
      repeat (gap) @(negedge clock);
      req_ch.valid = 1'b1;
      req_ch.func  = f;
      req_ch.addr  = a;
      req_ch.color = c;
      req_ch.pixel = p;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      apply_item(f, a, c, p);
      items_sent++;
      @(negedge clock);
      req_ch.valid = 1'b0;
   endtask

   task automatic send_produce();
      send_item(FUNC_PRODUCE, ADDR_W'($urandom_range(0, 4095)),
                COLOR_W'($urandom_range(0, 65535)), PIXEL_W'($urandom_range(0, 255)));
   endtask

   task automatic send_random_item();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         send_produce();
      end else if (pick < 85) begin
         send_item(FUNC_LOAD_SRC, ADDR_W'($urandom_range(0, 4095)),
                   COLOR_W'($urandom_range(0, 65535)),
                   ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 255)));
      end else if (pick < 96) begin
         send_item(FUNC_LOAD_PAL, ADDR_W'($urandom_range(0, 4095)),
                   COLOR_W'($urandom_range(0, 65535)), PIXEL_W'($urandom_range(0, 255)));
      end else begin
         send_item(FUNC_UNUSED, ADDR_W'($urandom_range(0, 4095)),
                   COLOR_W'($urandom_range(0, 65535)), PIXEL_W'($urandom_range(0, 255)));
      end
   endtask

   // hold until every pixel is back and the last load has left the pipe
   task automatic settle();
      while (pending_pixels.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(csr_idx_type idx, logic [CSR_DATA_W-1:0] data);
      csr_ch.valid = 1'b1;
      csr_ch.index = idx;
      csr_ch.data  = data;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      case (idx)
         CSR_STEP_X:     cfg_step_x = data[STEP_W-1:0];
         CSR_STEP_Y:     cfg_step_y = data[STEP_W-1:0];
         CSR_DST_WIDTH:  cfg_width  = data[DIM_W-1:0];
         CSR_DST_HEIGHT: cfg_height = data[DIM_W-1:0];
         CSR_SRC_STRIDE: cfg_stride = data[STRIDE_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   task automatic set_config(logic [STEP_W-1:0] sx, logic [STEP_W-1:0] sy,
                             logic [DIM_W-1:0] w, logic [DIM_W-1:0] h,
                             logic [STRIDE_W-1:0] stride);
      write_reg(CSR_STEP_X, CSR_DATA_W'(sx));
      write_reg(CSR_STEP_Y, CSR_DATA_W'(sy));
      write_reg(CSR_DST_WIDTH, CSR_DATA_W'(w));
      write_reg(CSR_DST_HEIGHT, CSR_DATA_W'(h));
      write_reg(CSR_SRC_STRIDE, CSR_DATA_W'(stride));
      settings_used++;
   endtask

   function automatic logic [STEP_W-1:0] odd_step();
      case ($urandom_range(0, 3))
         0:       return '0;
         1:       return STEP_W'(1);
         2:       return STEP_RESET;
         default: return '1;
      endcase
   endfunction

   // write every palette entry and the low source addresses that the walks read
   task automatic test_fill_memories();
      for (int i = 0; i < PAL_DEPTH; i++)
         send_item(FUNC_LOAD_PAL, ADDR_W'(i + 256 * $urandom_range(0, 15)),
                   COLOR_W'($urandom_range(0, 65535)), PIXEL_W'($urandom_range(0, 255)));
      for (int i = 0; i < SRC_FILL; i++)
         send_item(FUNC_LOAD_SRC, ADDR_W'(i), COLOR_W'($urandom_range(0, 65535)),
                   ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 255)));
   endtask

   task automatic test_directed();
      // reset registers: each pixel is a whole one-pixel frame read from address 0
      send_item(FUNC_LOAD_PAL, 12'hFFF, 16'hFFFF, 8'h00);
      send_item(FUNC_LOAD_SRC, 12'h000, 16'h0000, 8'hFF);
      send_produce();
      // unknown func must leave source 0 alone
      send_item(FUNC_UNUSED, 12'h000, 16'hFFFF, 8'h00);
      send_produce();
      send_item(FUNC_LOAD_SRC, 12'h000, 16'hFFFF, 8'h00);
      send_produce();
      send_item(FUNC_LOAD_PAL, 12'h101, 16'h0000, 8'hFF);
      send_item(FUNC_LOAD_SRC, 12'hFFF, 16'h0000, 8'h01);
      send_item(FUNC_LOAD_SRC, 12'h000, 16'h0000, 8'h01);
      send_produce();
      settle();
      // zero steps and zero stride: source address never moves
      set_config('0, '0, 11'd2, 11'd2, '0);
      repeat (4) send_produce();
      settle();
      // zero sizes clamp to one
      set_config(STEP_RESET, STEP_RESET, '0, '0, STRIDE_RESET);
      repeat (2) send_produce();
      settle();
      // oversized steps advance by one at most; stride wraps the row base
      set_config('1, '1, 11'd3, 11'd2, '1);
      repeat (6) send_produce();
   endtask

   // an oversized width clamps to the largest row; a slow step keeps reads low
   task automatic test_extreme_sizes();
      settle();
      sender_idles = 1'b0;
      sink_idles   = 1'b0;
      set_config(17'h00100, STEP_RESET, '1, 11'd1, 12'd1);
      repeat (1026) send_produce();
      sender_idles = 1'b1;
      sink_idles   = 1'b1;
   endtask

   task automatic test_random_frames();
      int dst_w;
      int dst_h;
      logic [STEP_W-1:0] sx;
      logic [STEP_W-1:0] sy;
      for (int ph = 0; ph < 3; ph++) begin
         settle();
         dst_w = $urandom_range(1, 8);
         dst_h = $urandom_range(1, 8);
         sx = ($urandom_range(0, 5) == 0) ? odd_step()
              : STEP_W'(($urandom_range(1, dst_w) << 16) / dst_w);
         sy = ($urandom_range(0, 5) == 0) ? odd_step()
              : STEP_W'(($urandom_range(1, dst_h) << 16) / dst_h);
         set_config(sx, sy, DIM_W'(dst_w), DIM_W'(dst_h), STRIDE_W'($urandom_range(0, 7)));
         sender_idles = ($urandom_range(0, 3) != 0);
         sink_idles   = ($urandom_range(0, 3) != 0);
         for (int n = 0; n < 30; n++) begin
            send_random_item();
            if ($urandom_range(0, 99) == 0) settle();
         end
      end
      sender_idles = 1'b1;
      sink_idles   = 1'b1;
   endtask

   task automatic test_backpressure();
      settle();
      set_config(17'h8000, 17'h5555, 11'd7, 11'd5, 12'd13);
      // stall the pixel side while requests keep coming, so input ready drops
      hold_off     = HOLD_CYCLES;
      sender_idles = 1'b0;
      repeat (40) send_random_item();
      sender_idles = 1'b1;
      settle();
      repeat (20) send_random_item();
   endtask

   initial begin
      reset        = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.func  = '0;
      req_ch.addr  = '0;
      req_ch.color = '0;
      req_ch.pixel = '0;
      csr_ch.valid = 1'b0;
      csr_ch.index = '0;
      csr_ch.data  = '0;
      acc_x      = '0;
      acc_y      = '0;
      column     = '0;
      line_base  = '0;
      col_pos    = '0;
      row_pos    = '0;
      cfg_step_x = STEP_RESET;
      cfg_step_y = STEP_RESET;
      cfg_width  = DIM_RESET;
      cfg_height = DIM_RESET;
      cfg_stride = STRIDE_RESET;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_fill_memories();
      test_directed();
      test_extreme_sizes();
      test_random_frames();
      test_backpressure();
      settle();

      $display("summary: %0d transactions sent, %0d pixels checked, %0d register settings",
               items_sent, pixels_checked, settings_used);
      $display("summary: loads, transparency, clamped sizes and steps, long stalls, %0d cycles",
               cycle_count);
      if (mismatches == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
